// File: design/ecb_pkg.sv
// Shared constants and types for the edge coverage bitmap unit.
// No dependencies; imported by the top level.
package ecb_pkg;

  // Bitmap size in bytes; must be a power of two.
  localparam int MAP_BYTES = 65536;
  localparam int MAP_AW    = $clog2(MAP_BYTES);

  localparam int ADDR_W   = 64;
  localparam int INDEX_W  = 16;
  localparam int POS_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE = 2'd1;

  // Result queue behind the read-modify-write stage.
  localparam int RQ_DEPTH = 3;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  // What the update stage does with a request.
  typedef enum logic [2:0] {
    OP_VISIT = 3'b001,
    OP_START = 3'b010,
    OP_SKIP  = 3'b100
  } op_t;

  typedef struct packed {
    logic               new_bit;
    logic               found_any;
    logic [INDEX_W-1:0] map_index;
    logic [POS_W-1:0]   bit_pos;
  } result_t;

endpackage

// File: design/edge_coverage_bitmap_unit.sv
// Edge coverage bitmap: hashes block-to-block edges into a byte bitmap.
// Depends on ecb_pkg for sizes, register indexes and types.
//
// The unit takes one request per clock cycle while in_ready is high and
// returns one result per request, by way of the update stage and the
// result queue. The rate is set by the bitmap memory's read-modify-write
// loop: a byte is read in the accept cycle and updated in the next, and a
// one-entry forwarding register covers a request that reads a byte the
// previous request is writing. After reset a clearing pass zeroes every
// bitmap byte with in_ready low; configuration writes are taken at all times.
module edge_coverage_bitmap_unit
  import ecb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [ADDR_W-1:0]    in_block_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_new_bit,
  output logic                 out_found_any,
  output logic [INDEX_W-1:0]   out_map_index,
  output logic [POS_W-1:0]     out_bit_pos,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  logic [7:0] map_mem [MAP_BYTES];

  logic              enabled_r, wide_mode_r;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic              flag_r, flag_nxt;
  logic              clr_busy_r;
  logic [MAP_AW-1:0] clr_addr_r;

  // Update stage.
  logic              s1_v_r;
  op_t               s1_op_r, s0_op;
  logic [MAP_AW-1:0] s1_idx_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [7:0]        rd_data_r;

  // Last byte written by the update stage.
  logic              fwd_v_r;
  logic [MAP_AW-1:0] fwd_addr_r;
  logic [7:0]        fwd_data_r;

  result_t           rq_mem [RQ_DEPTH];
  logic [RQ_PW-1:0]  rq_wp_r, rq_rp_r;
  logic [RQ_CW-1:0]  rq_cnt_r;

  logic              accept, pop, push;
  logic [22:0]       edge_lo;
  logic [18:0]       hash_lo;
  logic [MAP_AW-1:0] s0_idx;
  logic [7:0]        cur_byte, upd_byte, pos_mask;
  logic              fresh;
  result_t           s1_res;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_wa;
  logic [7:0]        mem_wd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clr_busy_r &&
                     (({1'b0, rq_cnt_r} + {{RQ_CW{1'b0}}, s1_v_r}) <= (RQ_CW+1)'(RQ_DEPTH - 1));
  assign accept    = in_valid && in_ready;

  // Only the low 23 bits of the edge reach bits 18:0 of the hash.
  always_comb begin
    if (wide_mode_r) begin
      edge_lo  = {prev_r[6:0], 16'b0} ^ in_block_addr[22:0];
      prev_nxt = in_block_addr;
    end else begin
      edge_lo  = {prev_r[14:0], 8'b0} ^ in_block_addr[22:0];
      prev_nxt = {32'b0, in_block_addr[31:0]};
    end
    hash_lo = edge_lo[22:4] ^ {edge_lo[10:0], 8'b0};
    s0_idx  = MAP_AW'(hash_lo[18:3]);
    if (in_func) s0_op = OP_START;
    else if (!enabled_r) s0_op = OP_SKIP;
    else s0_op = OP_VISIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      wide_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLED:   enabled_r   <= cfg_data;
        CFG_WIDE_MODE: wide_mode_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      case (s0_op)
        OP_START: prev_r <= '0;
        OP_VISIT: prev_r <= prev_nxt;
        default:  prev_r <= prev_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + MAP_AW'(1);
      if (clr_addr_r == {MAP_AW{1'b1}}) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= s0_op;
      s1_idx_r <= s0_idx;
      s1_pos_r <= hash_lo[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rd_data_r <= map_mem[s0_idx];
  end

  // A read issued in the cycle the previous request wrote the same byte
  // returns the stale value, so take the forwarded byte instead.
  always_comb begin
    cur_byte = (fwd_v_r && fwd_addr_r == s1_idx_r) ? fwd_data_r : rd_data_r;
    pos_mask = 8'b1 << s1_pos_r;
    upd_byte = cur_byte | pos_mask;
    fresh    = (cur_byte & pos_mask) == 8'b0;
    s1_res   = '0;
    flag_nxt = flag_r;
    case (s1_op_r)
      OP_VISIT: begin
        flag_nxt         = flag_r | fresh;
        s1_res.new_bit   = fresh;
        s1_res.map_index = INDEX_W'(s1_idx_r);
        s1_res.bit_pos   = s1_pos_r;
      end
      OP_START: flag_nxt = 1'b0;
      default:  flag_nxt = flag_r;
    endcase
    s1_res.found_any = flag_nxt;
  end

  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = 8'b0;
    end else begin
      mem_we = s1_v_r && (s1_op_r == OP_VISIT);
      mem_wa = s1_idx_r;
      mem_wd = upd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (s1_v_r) flag_r <= flag_nxt;
      fwd_v_r <= s1_v_r && (s1_op_r == OP_VISIT);
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_idx_r;
    fwd_data_r <= upd_byte;
  end

  // Result queue; in_ready leaves room for everything already in flight.
  assign push      = s1_v_r;
  assign out_valid = rq_cnt_r != '0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) rq_mem[rq_wp_r] <= s1_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= '0;
      rq_rp_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (push) begin
        rq_wp_r <= (rq_wp_r == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_wp_r + RQ_PW'(1);
      end
      if (pop) begin
        rq_rp_r <= (rq_rp_r == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_rp_r + RQ_PW'(1);
      end
      case ({push, pop})
        2'b10:   rq_cnt_r <= rq_cnt_r + RQ_CW'(1);
        2'b01:   rq_cnt_r <= rq_cnt_r - RQ_CW'(1);
        default: rq_cnt_r <= rq_cnt_r;
      endcase
    end
  end

  assign out_new_bit   = rq_mem[rq_rp_r].new_bit;
  assign out_found_any = rq_mem[rq_rp_r].found_any;
  assign out_map_index = rq_mem[rq_rp_r].map_index;
  assign out_bit_pos   = rq_mem[rq_rp_r].bit_pos;

endmodule

// File: design/ecb_checker.sv
// Port-level checks for the edge coverage bitmap unit, bound to the top level.
// Depends on ecb_pkg for port widths.
module ecb_checker
  import ecb_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_new_bit,
  input logic                 out_found_any,
  input logic [INDEX_W-1:0]   out_map_index,
  input logic [POS_W-1:0]     out_bit_pos
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_bit) &&
      $stable(out_found_any) && $stable(out_map_index) && $stable(out_bit_pos))
    else $error("stalled result changed");

  // A newly set bit always raises the sticky flag in the same result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_bit |-> out_found_any)
    else $error("new bit reported without found flag");

  // The bitmap clearing pass keeps requests out right after reset.
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("request accepted during bitmap clearing");

  // No result can be pending right after reset.
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result presented right after reset");

endmodule

bind edge_coverage_bitmap_unit ecb_checker u_ecb_checker (.*);

// File: bench/testbench.sv
// Self-checking testbench for edge_coverage_bitmap_unit: drives basic block
// traces and register writes, predicts every result and compares it.
// Depends on ecb_pkg and the design files; needs nothing else.
module testbench;
  import ecb_pkg::*;

  localparam logic FUNC_VISIT = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_PHASES   = 8;
  localparam int PHASE_VISITS = 160;
  localparam int POOL_SIZE    = 12;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] addr;
  } block_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = FUNC_VISIT;
  logic [ADDR_W-1:0]    in_block_addr = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_new_bit;
  logic                 out_found_any;
  logic [INDEX_W-1:0]   out_map_index;
  logic [POS_W-1:0]     out_bit_pos;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLED;
  logic                 cfg_data = 1'b0;

  // Shadow copy of the unit's state and registers.
  logic [7:0]        hit_bytes [MAP_BYTES];
  logic [ADDR_W-1:0] last_block = '0;
  logic              run_found = 1'b0;
  logic              enabled_reg = 1'b1;
  logic              wide_reg = 1'b1;

  block_req_t  trace_queue [$];
  result_t     expected_results [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_hold = 0;
  bit  steady = 1'b0;

  edge_coverage_bitmap_unit u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic result_t predict_step(input logic req_func,
                                           input logic [ADDR_W-1:0] addr);
    result_t           r;
    logic [63:0]       edge_v;
    logic [63:0]       hash;
    logic [31:0]       e32;
    logic [31:0]       h32;
    int unsigned       idx;
    logic [2:0]        pos;
    logic [7:0]        old_b;
    r = '0;
    if (req_func == FUNC_START) begin
      last_block = '0;
      run_found = 1'b0;
      return r;
    end
    if (!enabled_reg) begin
      r.found_any = run_found;
      return r;
    end
    if (wide_reg) begin
      edge_v = (last_block << 16) ^ addr;
      hash = (edge_v >> 4) ^ (edge_v << 8);
      last_block = addr;
    end else begin
      // Narrow mode works modulo 2^32, including a wide value left behind.
      e32 = (last_block[31:0] << 8) ^ addr[31:0];
      h32 = (e32 >> 4) ^ (e32 << 8);
      hash = {32'd0, h32};
      last_block = {32'd0, addr[31:0]};
    end
    idx = 32'(((hash >> 3) & 64'hffff) % MAP_BYTES);
    pos = hash[2:0];
    old_b = hit_bytes[idx];
    if (!old_b[pos]) begin
      hit_bytes[idx] = old_b | (8'd1 << pos);
      run_found = 1'b1;
      r.new_bit = 1'b1;
    end
    r.found_any = run_found;
    r.map_index = idx[INDEX_W-1:0];
    r.bit_pos = pos;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%s", msg);
  endtask

  // Request driver.
  always @(posedge clk) begin
    block_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_step(in_func, in_block_addr));
        send_gap = steady ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || trace_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = trace_queue.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_block_addr <= nxt.addr;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: new_bit %0b found_any %0b index %0h pos %0d",
                                 out_new_bit, out_found_any, out_map_index, out_bit_pos));
        end else begin
          want = expected_results.pop_front();
          if (want.new_bit !== out_new_bit || want.found_any !== out_found_any ||
              want.map_index !== out_map_index || want.bit_pos !== out_bit_pos)
            note_failure($sformatf(
              "mismatch: expected new_bit %0b found_any %0b index %0h pos %0d, got %0b %0b %0h %0d",
              want.new_bit, want.found_any, want.map_index, want.bit_pos,
              out_new_bit, out_found_any, out_map_index, out_bit_pos));
        end
        recv_hold = steady ? 0 : $urandom_range(0, 4);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_block(input logic f, input logic [ADDR_W-1:0] a);
    block_req_t b;
    b.func = f;
    b.addr = a;
    trace_queue.push_back(b);
  endtask

  task automatic wait_idle;
    do @(negedge clk);
    while (trace_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENABLED) enabled_reg = val;
    else if (idx == CFG_WIDE_MODE) wide_reg = val;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_trace(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) queue_block(FUNC_START, rand_addr());
      else if (roll < 12) queue_block(FUNC_VISIT, rand_addr());
      else queue_block(FUNC_VISIT, addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
    end
  endtask

  initial begin
    foreach (hit_bytes[i]) hit_bytes[i] = 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wide mode: repeated edges, all-zero and all-one addresses, and a new
    // run that must see old edges as already covered.
    queue_block(FUNC_VISIT, 64'd0);
    queue_block(FUNC_VISIT, 64'd0);
    queue_block(FUNC_VISIT, '1);
    queue_block(FUNC_VISIT, 64'h8000_0000_0000_0001);
    queue_block(FUNC_START, '1);
    queue_block(FUNC_VISIT, 64'd0);
    queue_block(FUNC_VISIT, '1);
    queue_block(FUNC_VISIT, 64'h0123_4567_89ab_cdef);
    queue_block(FUNC_VISIT, 64'hdead_beef_cafe_f00d);
    wait_idle();

    // Narrow mode picks up the wide address left behind, truncated.
    write_reg(CFG_WIDE_MODE, 1'b0);
    write_reg(CFG_UNUSED_A, 1'b1);
    write_reg(CFG_UNUSED_B, 1'b1);
    queue_block(FUNC_VISIT, '1);
    queue_block(FUNC_VISIT, 64'hffff_ffff_0000_0000);
    queue_block(FUNC_VISIT, 64'h0000_0000_ffff_ffff);
    queue_block(FUNC_START, 64'd0);
    queue_block(FUNC_VISIT, 64'd0);
    queue_block(FUNC_VISIT, 64'h5555_5555_aaaa_aaaa);
    wait_idle();

    // Disabled: visits only report the flag, a new run still clears it.
    write_reg(CFG_ENABLED, 1'b0);
    queue_block(FUNC_VISIT, '1);
    queue_block(FUNC_START, 64'h1234_5678_9abc_def0);
    queue_block(FUNC_VISIT, 64'h5555_5555_5555_5555);
    wait_idle();
    write_reg(CFG_ENABLED, 1'b1);
    write_reg(CFG_WIDE_MODE, 1'b1);

    // Random traces over a small set of blocks so edges recur; each phase
    // stops halfway until every result is back.
    for (int p = 0; p < RUN_PHASES; p++) begin
      if (p > 0) begin
        write_reg(CFG_ENABLED, $urandom_range(0, 3) != 0);
        write_reg(CFG_WIDE_MODE, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0)
          write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                    1'($urandom_range(0, 1)));
      end
      steady = (p % 3 == 2);
      foreach (addr_pool[i]) addr_pool[i] = rand_addr();
      queue_block(FUNC_START, rand_addr());
      queue_trace(PHASE_VISITS / 2);
      wait_idle();
      queue_trace(PHASE_VISITS / 2);
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/ecb_pkg.sv
design/edge_coverage_bitmap_unit.sv
design/ecb_checker.sv
bench/testbench.sv
